[sv/ut2t_pkg.sv]
// Shared constants, record type and digit helpers for the timestamp text block.
package ut2t_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 2;
    localparam int unsigned FRONT_LAT      = 13;

    localparam logic [63:0] SEC_LIMIT   = 64'd253402300800;
    localparam logic [7:0]  SEQ_MAX     = 8'd99;
    localparam logic [21:0] DAYS_MARCH0 = 22'd719468;
    localparam logic [21:0] DAYS_ERA    = 22'd146097;

    // reciprocals: ceil(2^S / d)
    localparam longint unsigned M_DAY  = ((64'd1 << 41) + 64'd674) / 64'd675;
    localparam longint unsigned M_ERA  = ((64'd1 << 40) + 64'd146096) / 64'd146097;
    localparam longint unsigned M_HOUR = ((64'd1 << 29) + 64'd3599) / 64'd3600;
    localparam longint unsigned M_MIN  = ((64'd1 << 18) + 64'd59) / 64'd60;
    localparam longint unsigned M_1460 = ((64'd1 << 29) + 64'd1459) / 64'd1460;
    localparam longint unsigned M_365  = ((64'd1 << 27) + 64'd364) / 64'd365;
    localparam longint unsigned M_153  = ((64'd1 << 19) + 64'd152) / 64'd153;
    localparam longint unsigned M_5    = ((64'd1 << 14) + 64'd4) / 64'd5;
    localparam longint unsigned M_100  = ((64'd1 << 21) + 64'd99) / 64'd100;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_Z    = 8'h5A;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_ERR  = 8'h00;

    localparam logic [4:0] IDX_Z    = 5'd15;
    localparam logic [4:0] IDX_LAST = 5'd18;

    typedef struct packed {
        logic       err;
        logic [6:0] seq;
        logic [6:0] yhi;
        logic [6:0] ylo;
        logic [3:0] mo;
        logic [4:0] dd;
        logic [4:0] hh;
        logic [5:0] mi;
        logic [5:0] ss;
    } t_rec;

    function automatic logic [3:0] tens(input logic [6:0] v);
        logic [17:0] p;
        p = 18'(v) * 18'd205;
        return p[14:11];
    endfunction

    function automatic logic [7:0] tens_char(input logic [6:0] v);
        return CH_ZERO + {4'd0, tens(v)};
    endfunction

    function automatic logic [7:0] ones_char(input logic [6:0] v);
        logic [6:0] o;
        o = v - 7'(tens(v)) * 7'd10;
        return CH_ZERO + {1'b0, o};
    endfunction

endpackage

[sv/unix_time_to_timestamp_text_top.sv]
// Top level: Unix seconds to YYYYMMDDTHHMMSSZ[-NN] text, one character per word.
// Each input word yields 16 characters, 19 with a nonzero sequence suffix, or one
// error word (character 0, status 1) when the sequence exceeds 99 or the date falls
// past year 9999. The character output moves one word per cycle while the receiver is
// ready. The front end holds one word while its multiply-by-reciprocal chain settles;
// a record queue lets it work on the next word while the back end is still emitting
// the previous one.
module unix_time_to_timestamp_text_top #(
    parameter int unsigned FIFO_DEPTH = ut2t_pkg::FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_created_seconds,
    input  logic [7:0]  i_sequence_number,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_text_char,
    output logic        o_last_char,
    output logic        o_status
);
    import ut2t_pkg::*;

    logic w_push, w_full, w_pop, w_rec_valid;
    t_rec w_rec_in, w_rec_out;

    ut2t_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_created_seconds (i_created_seconds),
        .i_sequence_number (i_sequence_number),
        .o_push            (w_push),
        .i_full            (w_full),
        .o_rec             (w_rec_in)
    );

    ut2t_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_rec_valid),
        .o_rec   (w_rec_out)
    );

    ut2t_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec_valid (w_rec_valid),
        .i_rec       (w_rec_out),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char),
        .o_status    (o_status)
    );

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last_char && (o_text_char == CH_ERR))
        else $error("error word not a single last word");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("record queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_rec_valid)
        else $error("record queue underflow");
endmodule

[sv/ut2t_front.sv]
// Front end: accepts a word, flags bad arguments and works out the date and time fields.
module ut2t_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [63:0]          i_created_seconds,
    input  logic [7:0]           i_sequence_number,
    output logic                 o_push,
    input  logic                 i_full,
    output ut2t_pkg::t_rec       o_rec
);
    import ut2t_pkg::*;

    logic        r_busy, n_busy;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_err;
    logic [6:0]  r_seq;
    logic [37:0] r_secs;

    logic [62:0] r_prod;
    logic [21:0] r_days, r_z;
    logic [16:0] r_sod;
    logic [4:0]  r_era, r_hh;
    logic [17:0] r_doe, r_n;
    logic [11:0] r_rem;
    logic [5:0]  r_mi, r_ss;
    logic [6:0]  r_q1460, r_yhi, r_ylo;
    logic [8:0]  r_yoe, r_doy;
    logic [3:0]  r_mp, r_mo;
    logic [4:0]  r_dd;
    logic [13:0] r_year;

    logic [38:0] p_t;
    logic [44:0] p_e;
    logic [34:0] p_h;
    logic [29:0] p_m;
    logic [36:0] p_q, p_y;
    logic [22:0] p_mp;
    logic [24:0] p_dd;
    logic [34:0] p_c;
    logic [10:0] v_mp, v_dd;
    logic [2:0]  c_36524;
    logic        c_146096;
    logic [1:0]  c_100;
    logic        accept;

    assign o_ready = !r_busy;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_busy && (r_cnt == 4'(FRONT_LAT)) && !i_full;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (accept) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (o_push) begin
            n_busy = 1'b0;
        end else if (r_busy && r_cnt != 4'(FRONT_LAT)) begin
            n_cnt = r_cnt + 4'd1;
        end
    end

    always_comb begin
        p_t  = 39'(r_days) * 39'd86400;
        p_e  = 45'(r_z) * 45'(M_ERA);
        p_h  = 35'(r_sod) * 35'(M_HOUR);
        p_m  = 30'(r_rem) * 30'(M_MIN);
        p_q  = 37'(r_doe) * 37'(M_1460);
        p_y  = 37'(r_n) * 37'(M_365);
        v_mp = 11'(r_doy) * 11'd5 + 11'd2;
        p_mp = 23'(v_mp) * 23'(M_153);
        v_dd = 11'(r_mp) * 11'd153 + 11'd2;
        p_dd = 25'(v_dd) * 25'(M_5);
        p_c  = 35'(r_year) * 35'(M_100);
        c_36524 = 3'(r_doe >= 18'd36524) + 3'(r_doe >= 18'd73048)
                + 3'(r_doe >= 18'd109572) + 3'(r_doe >= 18'd146096);
        c_146096 = (r_doe == 18'd146096);
        c_100 = 2'(r_yoe >= 9'd100) + 2'(r_yoe >= 9'd200) + 2'(r_yoe >= 9'd300);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_secs <= i_created_seconds[37:0];
            r_seq  <= i_sequence_number[6:0];
            r_err  <= (i_sequence_number > SEQ_MAX) || (i_created_seconds >= SEC_LIMIT);
        end
        r_prod  <= 63'(r_secs[37:7]) * 63'(M_DAY);
        r_days  <= r_prod[62:41];
        r_sod   <= 17'(r_secs - 38'(p_t));
        r_z     <= r_days + DAYS_MARCH0;
        r_era   <= 5'(p_e >> 40);
        r_doe   <= 18'(r_z - 22'(r_era) * DAYS_ERA);
        r_hh    <= 5'(p_h >> 29);
        r_rem   <= 12'(r_sod - 17'(r_hh) * 17'd3600);
        r_mi    <= 6'(p_m >> 18);
        r_ss    <= 6'(r_rem - 12'(r_mi) * 12'd60);
        r_q1460 <= 7'(p_q >> 29);
        r_n     <= r_doe - 18'(r_q1460) + 18'(c_36524) - 18'(c_146096);
        r_yoe   <= 9'(p_y >> 27);
        r_doy   <= 9'(r_doe - (18'(r_yoe) * 18'd365 + 18'(r_yoe[8:2]) - 18'(c_100)));
        r_mp    <= 4'(p_mp >> 19);
        r_dd    <= 5'(r_doy - 9'(p_dd >> 14) + 9'd1);
        r_mo    <= (r_mp < 4'd10) ? r_mp + 4'd3 : r_mp - 4'd9;
        r_year  <= 14'(r_yoe) + 14'(r_era) * 14'd400 + 14'(r_mp >= 4'd10);
        r_yhi   <= 7'(p_c >> 21);
        r_ylo   <= 7'(r_year - 14'(r_yhi) * 14'd100);
    end

    always_comb begin
        o_rec.err = r_err;
        o_rec.seq = r_seq;
        o_rec.yhi = r_yhi;
        o_rec.ylo = r_ylo;
        o_rec.mo  = r_mo;
        o_rec.dd  = r_dd;
        o_rec.hh  = r_hh;
        o_rec.mi  = r_mi;
        o_rec.ss  = r_ss;
    end
endmodule

[sv/ut2t_fifo.sv]
// Small record queue between the front end and the character back end.
module ut2t_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ut2t_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ut2t_pkg::t_rec o_rec
);
    import ut2t_pkg::*;

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_rec            r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            if (i_pop)
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wp] <= i_rec;
    end
endmodule

[sv/ut2t_back.sv]
// Back end: turns one record into a stream of ASCII characters.
module ut2t_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rec_valid,
    input  ut2t_pkg::t_rec i_rec,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_text_char,
    output logic           o_last_char,
    output logic           o_status
);
    import ut2t_pkg::*;

    logic       r_valid;
    logic [4:0] r_idx, n_idx;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic       r_status;
    logic       load;

    assign load  = !r_valid || i_ready;
    assign o_pop = load && i_rec_valid && n_last;

    always_comb begin
        n_char = CH_ERR;
        case (r_idx)
            5'd0:  n_char = tens_char(i_rec.yhi);
            5'd1:  n_char = ones_char(i_rec.yhi);
            5'd2:  n_char = tens_char(i_rec.ylo);
            5'd3:  n_char = ones_char(i_rec.ylo);
            5'd4:  n_char = tens_char({3'd0, i_rec.mo});
            5'd5:  n_char = ones_char({3'd0, i_rec.mo});
            5'd6:  n_char = tens_char({2'd0, i_rec.dd});
            5'd7:  n_char = ones_char({2'd0, i_rec.dd});
            5'd8:  n_char = CH_T;
            5'd9:  n_char = tens_char({2'd0, i_rec.hh});
            5'd10: n_char = ones_char({2'd0, i_rec.hh});
            5'd11: n_char = tens_char({1'b0, i_rec.mi});
            5'd12: n_char = ones_char({1'b0, i_rec.mi});
            5'd13: n_char = tens_char({1'b0, i_rec.ss});
            5'd14: n_char = ones_char({1'b0, i_rec.ss});
            5'd15: n_char = CH_Z;
            5'd16: n_char = CH_DASH;
            5'd17: n_char = tens_char(i_rec.seq);
            5'd18: n_char = ones_char(i_rec.seq);
            default: n_char = CH_ERR;
        endcase
        if (i_rec.err)
            n_char = CH_ERR;
        n_last = i_rec.err || (r_idx == IDX_LAST)
              || (r_idx == IDX_Z && i_rec.seq == 7'd0);
        n_idx = n_last ? 5'd0 : r_idx + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_rec_valid;
            if (i_rec_valid)
                r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_rec_valid) begin
            r_char   <= n_char;
            r_last   <= n_last;
            r_status <= i_rec.err;
        end
    end

    assign o_valid     = r_valid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;
    assign o_status    = r_status;
endmodule
